FILE: rtl/core/msp_pkg.sv
// ----------------------------------------------------------------------------
// msp_pkg: shared types and codes of the multi-stack slot pool
// Request and response structs plus the operation and status codes.
// ----------------------------------------------------------------------------
package msp_pkg;

  // Width of the fixed request and response fields.
  localparam int FUNC_W     = 2;
  localparam int STACK_ID_W = 2;
  localparam int VALUE_W    = 32;
  localparam int STATUS_W   = 2;

  // Number of stacks that the stack number field can address.
  localparam int STACK_IDS = 2 ** STACK_ID_W;

  // Operation codes; the fourth code is ignored.
  localparam logic [FUNC_W-1:0] FUNC_PUSH = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_POP  = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_PEEK = 2'd2;
  localparam logic [FUNC_W-1:0] FUNC_NOP  = 2'd3;

  // Status codes.
  localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_OVERFLOW = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_EMPTY    = 2'd2;

  typedef struct packed {
    logic [FUNC_W-1:0]            func;
    logic [STACK_ID_W-1:0]        stack_id;
    logic signed [VALUE_W-1:0]    push_value;
  } req_t;

  typedef struct packed {
    logic [STATUS_W-1:0]          status;
    logic signed [VALUE_W-1:0]    top_value;
  } rsp_t;

endpackage

FILE: rtl/core/multi_stack_shared_pool.sv
// ----------------------------------------------------------------------------
// multi_stack_shared_pool: several stacks sharing one linked slot pool
// Push, pop and peek on one of up to four stacks, with a free list of slots.
// ----------------------------------------------------------------------------
// Usage:
//   A request (operation, stack number, push value) enters on in_req_i when
//   in_valid_i is high and in_stall_o is low. Exactly one response (status,
//   top value) leaves on out_rsp_o, taken when out_valid_o is high and
//   out_stall_i is low.
//   In the accept cycle of a request the slot memories are read at the
//   free head or the stack top; when the request finishes, the link and
//   data memories are written back and the response is registered. The
//   slot memories are read through registers, so the block takes no new
//   request until the current one has finished.
//   The response leaves from its register once the request finishes. If the
//   receiver stalls, the finished request is held in its working register
//   and the input stays stalled until the response register is free.
//   After reset all stacks are empty and the free list runs through all
//   slots in order. No clearing pass is needed: a fill count marks which
//   slots have ever been linked, and untouched slots read as linked to the
//   next slot.
// ----------------------------------------------------------------------------
module multi_stack_shared_pool #(
  parameter int SLOTS     = 64,
  parameter int STACKS    = 4,
  parameter int DATA_BITS = 32
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  msp_pkg::req_t  in_req_i,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output msp_pkg::rsp_t  out_rsp_o
);

  localparam int LINK_W = $clog2(SLOTS + 1);
  localparam int ADDR_W = $clog2(SLOTS);
  localparam int HEADS  = (STACKS < msp_pkg::STACK_IDS) ? STACKS : msp_pkg::STACK_IDS;
  localparam int HEAD_W = (HEADS > 1) ? $clog2(HEADS) : 1;
  localparam logic [LINK_W-1:0] NULL_SLOT = LINK_W'(SLOTS);

  // Control state.
  logic                busy_q;
  logic                out_valid_q;
  logic [LINK_W-1:0]   free_head_q, free_head_d;
  logic [LINK_W-1:0]   fill_q, fill_d;
  logic [LINK_W-1:0]   head_q [HEADS];

  // Request in flight.
  msp_pkg::req_t       req_q;
  logic [LINK_W-1:0]   slot_q;
  msp_pkg::rsp_t       out_rsp_q, rsp_d;

  // Slot memories and their read registers.
  logic [LINK_W-1:0]           link_mem [SLOTS];
  logic [DATA_BITS-1:0]        data_mem [SLOTS];
  logic [LINK_W-1:0]           rd_link_q;
  logic signed [DATA_BITS-1:0] rd_data_q;

  logic                in_acc;
  logic                in_sid_ok;
  logic [LINK_W-1:0]   in_head;
  logic [LINK_W-1:0]   in_slot;
  logic                in_slot_ok;

  logic                complete;
  logic                sid_ok;
  logic [HEAD_W-1:0]   hidx;
  logic                slot_ok;
  logic [LINK_W-1:0]   link_val;
  logic                head_we;
  logic [LINK_W-1:0]   head_wdata;
  logic                link_we;
  logic [LINK_W-1:0]   link_wdata;
  logic                data_we;

  // Accept side: pick the slot that the request works on.
  assign in_acc     = in_valid_i & ~busy_q;
  assign in_stall_o = busy_q;
  assign in_sid_ok  = int'(in_req_i.stack_id) < STACKS;
  assign in_head    = in_sid_ok ? head_q[in_req_i.stack_id[HEAD_W-1:0]] : NULL_SLOT;
  assign in_slot    = (in_req_i.func == msp_pkg::FUNC_PUSH) ? free_head_q : in_head;
  assign in_slot_ok = in_slot != NULL_SLOT;

  // Finish side: the request finishes when the response register can take it.
  assign complete = busy_q & (~out_valid_q | ~out_stall_i);
  assign sid_ok   = int'(req_q.stack_id) < STACKS;
  assign hidx     = req_q.stack_id[HEAD_W-1:0];
  assign slot_ok  = slot_q != NULL_SLOT;

  // Slots at or above the fill count were never linked and point to the next slot.
  assign link_val = (slot_q >= fill_q) ? LINK_W'(slot_q + 1'b1) : rd_link_q;

  // Update of the lists and the response.
  always_comb begin
    free_head_d = free_head_q;
    fill_d      = fill_q;
    head_we     = 1'b0;
    head_wdata  = slot_q;
    link_we     = 1'b0;
    link_wdata  = free_head_q;
    data_we     = 1'b0;
    rsp_d.status    = msp_pkg::STATUS_OK;
    rsp_d.top_value = '0;
    if (req_q.func != msp_pkg::FUNC_NOP && !sid_ok) begin
      rsp_d.status = msp_pkg::STATUS_EMPTY;
      if (req_q.func == msp_pkg::FUNC_PEEK) begin
        rsp_d.top_value = '1;
      end
    end else begin
      case (req_q.func)
        msp_pkg::FUNC_PUSH: begin
          if (!slot_ok) begin
            rsp_d.status = msp_pkg::STATUS_OVERFLOW;
          end else begin
            free_head_d = link_val;
            link_we     = 1'b1;
            link_wdata  = head_q[hidx];
            head_we     = 1'b1;
            head_wdata  = slot_q;
            data_we     = 1'b1;
            if (slot_q == fill_q) begin
              fill_d = LINK_W'(fill_q + 1'b1);
            end
          end
        end
        msp_pkg::FUNC_POP: begin
          if (!slot_ok) begin
            rsp_d.status = msp_pkg::STATUS_EMPTY;
          end else begin
            head_we     = 1'b1;
            head_wdata  = link_val;
            link_we     = 1'b1;
            link_wdata  = free_head_q;
            free_head_d = slot_q;
          end
        end
        msp_pkg::FUNC_PEEK: begin
          if (!slot_ok) begin
            rsp_d.status    = msp_pkg::STATUS_EMPTY;
            rsp_d.top_value = '1;
          end else begin
            rsp_d.top_value = msp_pkg::VALUE_W'(rd_data_q);
          end
        end
        default: begin
          rsp_d.status = msp_pkg::STATUS_OK;
        end
      endcase
    end
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      out_valid_q <= 1'b0;
      free_head_q <= '0;
      fill_q      <= '0;
      for (int i = 0; i < HEADS; i++) begin
        head_q[i] <= NULL_SLOT;
      end
    end else begin
      if (in_acc) begin
        busy_q <= 1'b1;
      end else if (complete) begin
        busy_q <= 1'b0;
      end
      if (complete) begin
        out_valid_q <= 1'b1;
        free_head_q <= free_head_d;
        fill_q      <= fill_d;
        if (head_we) begin
          head_q[hidx] <= head_wdata;
        end
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Request and response payload.
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      req_q  <= in_req_i;
      slot_q <= in_slot;
    end
    if (complete) begin
      out_rsp_q <= rsp_d;
    end
  end

  // Link memory: read at acceptance, written when the request finishes.
  always_ff @(posedge clk_i) begin
    if (complete && link_we) begin
      link_mem[slot_q[ADDR_W-1:0]] <= link_wdata;
    end
    if (in_acc && in_slot_ok) begin
      rd_link_q <= link_mem[in_slot[ADDR_W-1:0]];
    end
  end

  // Data memory: a push writes the sign-extended value, a peek reads the top.
  always_ff @(posedge clk_i) begin
    if (complete && data_we) begin
      data_mem[slot_q[ADDR_W-1:0]] <= DATA_BITS'($signed(req_q.push_value));
    end
    if (in_acc && in_slot_ok) begin
      rd_data_q <= data_mem[in_slot[ADDR_W-1:0]];
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_rsp_q;

endmodule

FILE: rtl/core/msp_checker.sv
// ----------------------------------------------------------------------------
// msp_checker: port-level checks for the multi-stack slot pool
// Watches the request and response channels of the top level.
// ----------------------------------------------------------------------------
module msp_checker (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           in_valid_i,
  input logic           in_stall_o,
  input msp_pkg::req_t  in_req_i,
  input logic           out_valid_o,
  input logic           out_stall_i,
  input msp_pkg::rsp_t  out_rsp_o
);

  // A stalled response stays and does not change.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_rsp_o))
    else $error("stalled response changed");

  // An accepted request occupies the block for the next cycle.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("request accepted without occupying the block");

  // Only the defined status codes appear.
  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_rsp_o.status == msp_pkg::STATUS_OK ||
                     out_rsp_o.status == msp_pkg::STATUS_OVERFLOW ||
                     out_rsp_o.status == msp_pkg::STATUS_EMPTY))
    else $error("reserved status code on response");

  // An overflow carries a zero value.
  a_overflow_value: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_rsp_o.status == msp_pkg::STATUS_OVERFLOW
      |-> out_rsp_o.top_value == '0)
    else $error("overflow response with nonzero value");

endmodule

bind multi_stack_shared_pool msp_checker u_msp_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .in_req_i    (in_req_i),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_rsp_o   (out_rsp_o)
);
